FILE: hdl/rgpc_pkg.sv
// Shared constants, codes and types for the RMS grayscale pixel converter.
// Used by rgpc_gray_unit and rms_grayscale_pixel_converter_top; no dependencies.
package rgpc_pkg;

  // Fraction bits of the reciprocal-luminance register (unsigned Q4.12).
  localparam int RECIP_FRACTION_BITS = 12;

  // Datapath widths, all derived from the field widths and the fraction bits.
  localparam int CHAN_W     = 8;
  localparam int SUM_W      = 18;                        // r*r + g*g + b*b
  localparam int INV_W      = 16;
  localparam int PROD_W     = SUM_W + INV_W;
  localparam int SCALED_W   = PROD_W - RECIP_FRACTION_BITS;
  localparam int ROOT_W     = (SCALED_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQ_CNT_W   = $clog2(ROOT_W);
  localparam int MUL_CNT_W  = 2;

  // Multiplier steps: red, green and blue squares, then the luminance scale.
  localparam logic [MUL_CNT_W-1:0] MUL_RED   = 2'd0;
  localparam logic [MUL_CNT_W-1:0] MUL_GREEN = 2'd1;
  localparam logic [MUL_CNT_W-1:0] MUL_BLUE  = 2'd2;
  localparam logic [MUL_CNT_W-1:0] MUL_SCALE = 2'd3;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_LUMINANCE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_ENABLE    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLOR     = 8'd3;

  // Pixel format codes; bit 1 selects the 16-bit 5-5-5 format.
  localparam logic [1:0] FMT_PALETTE = 2'd0;
  localparam logic [1:0] FMT_RGB24   = 2'd1;
  localparam logic [1:0] FMT_RGB555  = 2'd2;

  // Reset values of the registers.
  localparam logic [INV_W-1:0] INV_LUMINANCE_RESET = 16'd1638;

  typedef enum logic [1:0] {
    GU_IDLE,
    GU_MUL,
    GU_SQRT,
    GU_DONE
  } gu_state_t;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } top_state_t;

  // Control from the top level to the gray unit.
  typedef struct packed {
    logic start;
    logic ack;
  } gu_ctrl_t;

  // Status from the gray unit to the top level.
  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] gray;
  } gu_stat_t;

endpackage

FILE: hdl/rgpc_gray_unit.sv
// Gray level unit: one shared multiplier for the sum of squares and the
// luminance scale, then a digit-by-digit square root. Depends on rgpc_pkg.
module rgpc_gray_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  rgpc_pkg::gu_ctrl_t              ctrl,
  input  logic [rgpc_pkg::CHAN_W-1:0]     red,
  input  logic [rgpc_pkg::CHAN_W-1:0]     green,
  input  logic [rgpc_pkg::CHAN_W-1:0]     blue,
  input  logic [rgpc_pkg::INV_W-1:0]      inv_luminance,
  output rgpc_pkg::gu_stat_t              stat
);

  rgpc_pkg::gu_state_t state, state_next;

  logic [rgpc_pkg::MUL_CNT_W-1:0] mul_cnt;
  logic [rgpc_pkg::SQ_CNT_W-1:0]  sq_cnt;
  logic [rgpc_pkg::SUM_W-1:0]     acc;
  logic [rgpc_pkg::RAD_W-1:0]     rad;
  logic [rgpc_pkg::REM_W-1:0]     rem;
  logic [rgpc_pkg::ROOT_W-1:0]    root;

  logic [rgpc_pkg::CHAN_W-1:0]    chan;
  logic                           mul_sq;
  logic [rgpc_pkg::SUM_W-1:0]     mul_a;
  logic [rgpc_pkg::INV_W-1:0]     mul_b;
  logic [rgpc_pkg::PROD_W-1:0]    mul_p;

  logic [rgpc_pkg::REM_W-1:0]     rem_sh;
  logic [rgpc_pkg::REM_W-1:0]     trial;
  logic                           fits;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (mul_cnt)
      rgpc_pkg::MUL_RED:   chan = red;
      rgpc_pkg::MUL_GREEN: chan = green;
      default:             chan = blue;
    endcase
    mul_sq = (mul_cnt != rgpc_pkg::MUL_SCALE);
    mul_a  = mul_sq ? rgpc_pkg::SUM_W'(chan) : acc;
    mul_b  = mul_sq ? rgpc_pkg::INV_W'(chan) : inv_luminance;
    mul_p  = rgpc_pkg::PROD_W'(mul_a) * rgpc_pkg::PROD_W'(mul_b);
  end

  // One square root digit: bring down two radicand bits and try the next bit.
  always_comb begin
    rem_sh = {rem[rgpc_pkg::REM_W-3:0], rad[rgpc_pkg::RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgpc_pkg::GU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and status.
  always_comb begin
    state_next = state;
    case (state)
      rgpc_pkg::GU_IDLE: begin
        if (ctrl.start) begin
          state_next = rgpc_pkg::GU_MUL;
        end
      end
      rgpc_pkg::GU_MUL: begin
        if (mul_cnt == rgpc_pkg::MUL_SCALE) begin
          state_next = rgpc_pkg::GU_SQRT;
        end
      end
      rgpc_pkg::GU_SQRT: begin
        if (sq_cnt == '0) begin
          state_next = rgpc_pkg::GU_DONE;
        end
      end
      rgpc_pkg::GU_DONE: begin
        if (ctrl.ack) begin
          state_next = rgpc_pkg::GU_IDLE;
        end
      end
      default: state_next = rgpc_pkg::GU_IDLE;
    endcase
    stat.done = (state == rgpc_pkg::GU_DONE);
    stat.gray = root[rgpc_pkg::CHAN_W-1:0];
  end

  // Step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
      sq_cnt  <= '0;
    end else begin
      case (state)
        rgpc_pkg::GU_IDLE: begin
          mul_cnt <= '0;
          sq_cnt  <= rgpc_pkg::SQ_CNT_W'(rgpc_pkg::ROOT_W - 1);
        end
        rgpc_pkg::GU_MUL:  mul_cnt <= mul_cnt + 1'b1;
        rgpc_pkg::GU_SQRT: sq_cnt  <= sq_cnt - 1'b1;
        default: begin
          mul_cnt <= mul_cnt;
          sq_cnt  <= sq_cnt;
        end
      endcase
    end
  end

  // Datapath: accumulate the squares, scale, then iterate the square root.
  always_ff @(posedge clk) begin
    if (state == rgpc_pkg::GU_MUL) begin
      if (mul_cnt == rgpc_pkg::MUL_RED) begin
        acc <= rgpc_pkg::SUM_W'(mul_p);
      end else if (mul_sq) begin
        acc <= acc + rgpc_pkg::SUM_W'(mul_p);
      end else begin
        rad  <= rgpc_pkg::RAD_W'(mul_p >> rgpc_pkg::RECIP_FRACTION_BITS);
        rem  <= '0;
        root <= '0;
      end
    end else if (state == rgpc_pkg::GU_SQRT) begin
      rad  <= rad << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[rgpc_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/rms_grayscale_pixel_converter_top.sv
// Top level of the RMS grayscale pixel converter: stream ports, registers,
// key colour tracking and result formatting. Depends on rgpc_pkg, rgpc_gray_unit.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  s_tdata 40 bits, s_tuser 1 bit
//   m_*       out        m_tvalid/m_tready  m_tdata 64 bits, m_tuser 1 bit
//   cfg_*     in         cfg_valid/cfg_ready cfg_index 8 bits, cfg_data 24 bits
//
// A word goes through four passes of the shared multiplier, eleven square root
// digits at one per cycle and a hand-over on its way from acceptance to a result
// in the output register. The input is not ready meanwhile and opens the cycle
// after the hand-over, so a new word is not taken before the last is handed over. The
// hand-over waits while the output register still holds an untaken result.
// Reset is synchronous and restores the register defaults.
module rms_grayscale_pixel_converter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: red [7:0], green [15:8], blue [23:16], packed_pixel [39:24]
  input  logic [39:0]                          s_tdata,
  // s_tuser: start_of_image [0]
  input  logic [0:0]                           s_tuser,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // m_tdata: out_red [7:0], out_green [15:8], out_blue [23:16],
  //          out_packed [39:24], new_key_color [63:40]
  output logic [63:0]                          m_tdata,
  // m_tuser: key_replaced [0]
  output logic [0:0]                           m_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rgpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [1:0]                    pixel_format;
  logic [rgpc_pkg::INV_W-1:0]    inv_luminance;
  logic                          key_enable;
  logic [23:0]                   key_color;

  logic                          key_found;

  rgpc_pkg::top_state_t state, state_next;
  rgpc_pkg::gu_ctrl_t   gu_ctrl;
  rgpc_pkg::gu_stat_t   gu_stat;

  // Held word.
  logic                          sop;
  logic                          fmt16;
  logic                          passthru;
  logic [rgpc_pkg::CHAN_W-1:0]   red;
  logic [rgpc_pkg::CHAN_W-1:0]   green;
  logic [rgpc_pkg::CHAN_W-1:0]   blue;

  logic                          s_accept;
  logic                          load;
  logic                          in_fmt16;
  logic [rgpc_pkg::CHAN_W-1:0]   in_red;
  logic [rgpc_pkg::CHAN_W-1:0]   in_green;
  logic [rgpc_pkg::CHAN_W-1:0]   in_blue;

  logic                          found_eff;
  logic                          match;
  logic [rgpc_pkg::CHAN_W-1:0]   gray;
  logic [15:0]                   packed_gray;

  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign gray      = gu_stat.gray;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= rgpc_pkg::FMT_RGB24;
      inv_luminance <= rgpc_pkg::INV_LUMINANCE_RESET;
      key_enable    <= 1'b0;
      key_color     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgpc_pkg::REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[1:0];
        rgpc_pkg::REG_INV_LUMINANCE: inv_luminance <= cfg_data[rgpc_pkg::INV_W-1:0];
        rgpc_pkg::REG_KEY_ENABLE:    key_enable    <= cfg_data[0];
        rgpc_pkg::REG_KEY_COLOR:     key_color     <= cfg_data[23:0];
        default:                     key_enable    <= key_enable;
      endcase
    end
  end

  // Unpack the incoming word; the 16-bit format zero-extends its 5-bit channels.
  always_comb begin
    in_fmt16 = pixel_format[1];
    if (in_fmt16) begin
      in_red   = {3'b000, s_tdata[38:34]};
      in_green = {3'b000, s_tdata[33:29]};
      in_blue  = {3'b000, s_tdata[28:24]};
    end else begin
      in_red   = s_tdata[7:0];
      in_green = s_tdata[15:8];
      in_blue  = s_tdata[23:16];
    end
  end

  // Hold the word while the gray unit works on it.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      sop      <= s_tuser[0];
      fmt16    <= in_fmt16;
      passthru <= (pixel_format == rgpc_pkg::FMT_PALETTE) &&
                  (s_tdata[7:0] == s_tdata[15:8]) && (s_tdata[15:8] == s_tdata[23:16]);
      red      <= in_red;
      green    <= in_green;
      blue     <= in_blue;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgpc_pkg::TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: accept a word, wait for the gray level, hand over the result.
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    load          = 1'b0;
    gu_ctrl.start = 1'b0;
    gu_ctrl.ack   = 1'b0;
    case (state)
      rgpc_pkg::TOP_IDLE: begin
        s_tready      = 1'b1;
        gu_ctrl.start = s_tvalid;
        if (s_tvalid) begin
          state_next = rgpc_pkg::TOP_BUSY;
        end
      end
      rgpc_pkg::TOP_BUSY: begin
        if (gu_stat.done && (!m_tvalid || m_tready)) begin
          load        = 1'b1;
          gu_ctrl.ack = 1'b1;
          state_next  = rgpc_pkg::TOP_IDLE;
        end
      end
      default: state_next = rgpc_pkg::TOP_IDLE;
    endcase
  end

  // Key colour check; a start of image clears the found flag first.
  always_comb begin
    found_eff   = key_found && !sop;
    match       = !passthru && key_enable && !found_eff &&
                  ({blue, green, red} == key_color);
    packed_gray = 16'(gray) | (16'(gray) << 5) | (16'(gray) << 10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_found <= 1'b0;
    end else if (load) begin
      key_found <= found_eff || match;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[7:0]   <= passthru ? red   : gray;
      m_tdata[15:8]  <= passthru ? green : gray;
      m_tdata[23:16] <= passthru ? blue  : gray;
      m_tdata[39:24] <= fmt16 ? packed_gray : 16'd0;
      m_tdata[63:40] <= match ? {gray, gray, gray} : 24'd0;
      m_tuser[0]     <= match;
    end
  end

  rgpc_gray_unit u_gray (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (gu_ctrl),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .inv_luminance (inv_luminance),
    .stat          (gu_stat)
  );

  // A word is accepted only once; the input closes the cycle after.
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("input still ready after a word was accepted");

  // The gray unit finishes only while a word is held.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    gu_stat.done |-> (state == rgpc_pkg::TOP_BUSY))
    else $error("gray unit finished with no word held");

  // A replaced key carries the same gray byte three times.
  a_key_gray: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      ((m_tdata[47:40] == m_tdata[55:48]) && (m_tdata[55:48] == m_tdata[63:56])
       && (m_tdata[7:0] == m_tdata[47:40])))
    else $error("key replacement colour differs from the gray level");

  // Without key tracking no key is ever reported.
  a_key_enabled: assert property (@(posedge clk) disable iff (rst)
    load && !key_enable |=> !m_tuser[0])
    else $error("key reported while key tracking is off");

endmodule
